[design/prts_pkg.sv]
// Shared types, widths and constants for the point rotate/translate/scale block.
// No dependencies; every other design file imports this package.
package prts_pkg;

    localparam int TW    = 32;          // trig value, Q30 signed
    localparam int CXW   = 33;          // CORDIC x/y working width
    localparam int CZW   = 32;          // CORDIC residual angle width
    localparam int CW    = 36;          // rotation intermediate coordinate width
    localparam int PW    = CW + TW;     // product width
    localparam int RW    = 56;          // divider remainder width
    localparam int QW    = 32;          // quotient bits
    localparam int NCELL = QW;          // cells in the chain

    localparam logic [1:0] ACT_ROTATE    = 2'd0;
    localparam logic [1:0] ACT_TRANSLATE = 2'd1;
    localparam logic [1:0] ACT_DISPLACE  = 2'd2;

    localparam logic [2:0] REG_ANGLE_X  = 3'd0;
    localparam logic [2:0] REG_ANGLE_Y  = 3'd1;
    localparam logic [2:0] REG_ANGLE_Z  = 3'd2;
    localparam logic [2:0] REG_OFFSET_X = 3'd3;
    localparam logic [2:0] REG_OFFSET_Y = 3'd4;
    localparam logic [2:0] REG_OFFSET_Z = 3'd5;

    localparam logic signed [CXW-1:0] CORDIC_START = 33'sh026DD3B6A;

    typedef struct packed {
        logic signed [CXW-1:0] x;
        logic signed [CXW-1:0] y;
        logic signed [CZW-1:0] z;
        logic [1:0]            quad;
    } cordic_t;

    typedef struct packed {
        logic [RW-1:0] rem;
        logic [31:0]   den;
        logic [QW-1:0] quo;
        logic          ovf;
        logic          zero;
        logic          neg;
        logic          ppos;
        logic          pneg;
    } div_t;

    typedef struct packed {
        logic [1:0]       action;
        logic [2:0][31:0] p;
        cordic_t [2:0]    cord;
        div_t [2:0]       dv;
    } cell_t;

    typedef struct packed {
        logic [1:0]         action;
        logic [2:0][31:0]   alt;
        logic               alt_flag;
        logic [2:0][TW-1:0] c;
        logic [2:0][TW-1:0] s;
    } side_t;

    function automatic logic signed [CZW-1:0] atan_val(input int i);
        case (i)
            0:       return 32'sh20000000;
            1:       return 32'sh12E4051D;
            2:       return 32'sh09FB385B;
            3:       return 32'sh051111D4;
            4:       return 32'sh028B0D43;
            5:       return 32'sh0145D7E1;
            6:       return 32'sh00A2F61E;
            7:       return 32'sh00517C55;
            8:       return 32'sh0028BE53;
            9:       return 32'sh00145F2E;
            10:      return 32'sh000A2F98;
            11:      return 32'sh000517CC;
            12:      return 32'sh00028BE6;
            13:      return 32'sh000145F3;
            14:      return 32'sh0000A2F9;
            15:      return 32'sh0000517C;
            16:      return 32'sh000028BE;
            17:      return 32'sh0000145F;
            18:      return 32'sh00000A2F;
            19:      return 32'sh00000517;
            20:      return 32'sh0000028B;
            21:      return 32'sh00000145;
            22:      return 32'sh000000A2;
            23:      return 32'sh00000051;
            24:      return 32'sh00000028;
            25:      return 32'sh00000014;
            26:      return 32'sh0000000A;
            27:      return 32'sh00000005;
            28:      return 32'sh00000002;
            29:      return 32'sh00000001;
            default: return 32'sh00000000;
        endcase
    endfunction

endpackage

[design/prts_cell.sv]
// One cell of the chain: one restoring-division quotient bit per axis and,
// if STAGE < CORDIC_STAGES, a CORDIC iteration per angle. Depends on prts_pkg.
module prts_cell
    import prts_pkg::*;
#(
    parameter int STAGE         = 0,
    parameter int CORDIC_STAGES = 18
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  cell_t in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output cell_t out_data
);

    localparam int QB = QW - 1 - STAGE;
    localparam logic signed [CZW-1:0] ATAN = atan_val(STAGE);

    logic  valid_reg;
    cell_t data_reg;
    cell_t data_next;
    logic  adv;
    logic signed [CXW-1:0] xs [3];
    logic signed [CXW-1:0] ys [3];
    logic [63:0] dsh [3];

    assign adv       = !valid_reg || out_ready;
    assign in_ready  = adv;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        data_next = in_data;
        for (int a = 0; a < 3; a++)
        begin
            xs[a]  = $signed(in_data.cord[a].x) >>> STAGE;
            ys[a]  = $signed(in_data.cord[a].y) >>> STAGE;
            dsh[a] = 64'(in_data.dv[a].den) << QB;
            if (STAGE < CORDIC_STAGES)
            begin
                if ($signed(in_data.cord[a].z) >= 0)
                begin
                    data_next.cord[a].x = $signed(in_data.cord[a].x) - ys[a];
                    data_next.cord[a].y = $signed(in_data.cord[a].y) + xs[a];
                    data_next.cord[a].z = $signed(in_data.cord[a].z) - ATAN;
                end
                else
                begin
                    data_next.cord[a].x = $signed(in_data.cord[a].x) + ys[a];
                    data_next.cord[a].y = $signed(in_data.cord[a].y) - xs[a];
                    data_next.cord[a].z = $signed(in_data.cord[a].z) + ATAN;
                end
            end
            if (64'(in_data.dv[a].rem) >= dsh[a])
            begin
                data_next.dv[a].rem     = in_data.dv[a].rem - RW'(dsh[a]);
                data_next.dv[a].quo[QB] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            data_reg <= data_next;
    end

endmodule

[design/prts_post.sv]
// Back end: trig clamp and quadrant map, divide finish, translate, three
// rotation stages and the output register. Depends on prts_pkg.
module prts_post
    import prts_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  cell_t            in_data,
    input  logic [2:0][31:0] offset,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [95:0]      out_data,
    output logic             out_flag
);

    localparam int NS = 7;
    localparam logic signed [CXW-1:0] TRIG_HI = 33'sd1073741824;
    localparam logic signed [CXW-1:0] TRIG_LO = -33'sd1073741824;
    localparam logic signed [PW:0]    RND_HALF = (PW+1)'(64'sd536870912);
    localparam logic signed [CW-1:0]  SAT_HI = CW'(64'sd2147483647);
    localparam logic signed [CW-1:0]  SAT_LO = CW'(-64'sd2147483648);

    function automatic logic signed [CW-1:0] rnd30(input logic signed [PW:0] v);
        logic signed [PW:0] t;
        t = v + RND_HALF;
        return CW'(t >>> 30);
    endfunction

    function automatic logic signed [PW:0] wx(input logic signed [PW-1:0] v);
        return (PW+1)'(v);
    endfunction

    logic v_reg [NS];
    logic adv [NS];
    side_t side_reg [NS-1];
    side_t side_next;

    logic signed [CW-1:0] tx_reg, ty_reg, tz_reg;
    logic signed [CW-1:0] m1_x_reg, m2_y_reg, m3_z_reg;
    logic signed [PW-1:0] m1_p_reg [4];
    logic signed [PW-1:0] m2_p_reg [4];
    logic signed [PW-1:0] m3_p_reg [4];
    logic signed [CW-1:0] a1_x_reg, a1_y_reg, a1_z_reg;
    logic signed [CW-1:0] a2_x_reg, a2_y_reg, a2_z_reg;
    logic [95:0] out_data_reg, out_data_next;
    logic        out_flag_reg, out_flag_next;

    logic signed [CXW-1:0] cx [3];
    logic signed [CXW-1:0] cy [3];
    logic signed [TW-1:0]  cc [3];
    logic signed [TW-1:0]  ss [3];
    logic [31:0]           disp [3];
    logic [31:0]           trn [3];
    logic signed [32:0]    tsum [3];
    logic                  dflag, tflag, rflag;
    logic signed [CW-1:0]  r [3];

    always_comb
    begin
        adv[NS-1] = !v_reg[NS-1] || out_ready;
        for (int k = NS - 2; k >= 0; k--)
            adv[k] = !v_reg[k] || adv[k+1];
    end

    assign in_ready  = adv[0];
    assign out_valid = v_reg[NS-1];
    assign out_data  = out_data_reg;
    assign out_flag  = out_flag_reg;

    always_comb
    begin
        dflag = 1'b0;
        tflag = 1'b0;
        side_next.action = in_data.action;
        for (int a = 0; a < 3; a++)
        begin
            cx[a] = $signed(in_data.cord[a].x);
            cy[a] = $signed(in_data.cord[a].y);
            if (cx[a] > TRIG_HI)
                cc[a] = TW'(TRIG_HI);
            else if (cx[a] < TRIG_LO)
                cc[a] = TW'(TRIG_LO);
            else
                cc[a] = TW'(cx[a]);
            if (cy[a] > TRIG_HI)
                ss[a] = TW'(TRIG_HI);
            else if (cy[a] < TRIG_LO)
                ss[a] = TW'(TRIG_LO);
            else
                ss[a] = TW'(cy[a]);
            case (in_data.cord[a].quad)
                2'd0:
                begin
                    side_next.c[a] = cc[a];
                    side_next.s[a] = ss[a];
                end
                2'd1:
                begin
                    side_next.c[a] = -ss[a];
                    side_next.s[a] = cc[a];
                end
                2'd2:
                begin
                    side_next.c[a] = -cc[a];
                    side_next.s[a] = -ss[a];
                end
                default:
                begin
                    side_next.c[a] = ss[a];
                    side_next.s[a] = -cc[a];
                end
            endcase

            if (in_data.dv[a].zero)
            begin
                dflag = 1'b1;
                if (in_data.dv[a].ppos)
                    disp[a] = 32'h7FFFFFFF;
                else if (in_data.dv[a].pneg)
                    disp[a] = 32'h80000000;
                else
                    disp[a] = 32'h0;
            end
            else if (in_data.dv[a].ovf)
            begin
                dflag   = 1'b1;
                disp[a] = in_data.dv[a].neg ? 32'h80000000 : 32'h7FFFFFFF;
            end
            else if (!in_data.dv[a].neg)
            begin
                if (in_data.dv[a].quo > 32'h7FFFFFFF)
                begin
                    dflag   = 1'b1;
                    disp[a] = 32'h7FFFFFFF;
                end
                else
                    disp[a] = in_data.dv[a].quo;
            end
            else
            begin
                if (in_data.dv[a].quo > 32'h80000000)
                begin
                    dflag   = 1'b1;
                    disp[a] = 32'h80000000;
                end
                else
                    disp[a] = ~in_data.dv[a].quo + 32'd1;
            end

            tsum[a] = 33'($signed(in_data.p[a])) + 33'($signed(offset[a]));
            if (tsum[a] > 33'sd2147483647)
            begin
                tflag  = 1'b1;
                trn[a] = 32'h7FFFFFFF;
            end
            else if (tsum[a] < -33'sd2147483648)
            begin
                tflag  = 1'b1;
                trn[a] = 32'h80000000;
            end
            else
                trn[a] = tsum[a][31:0];
        end

        case (in_data.action)
            ACT_TRANSLATE:
            begin
                side_next.alt      = {trn[2], trn[1], trn[0]};
                side_next.alt_flag = tflag;
            end
            ACT_DISPLACE:
            begin
                side_next.alt      = {disp[2], disp[1], disp[0]};
                side_next.alt_flag = dflag;
            end
            default:
            begin
                side_next.alt      = in_data.p;
                side_next.alt_flag = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        r[0] = rnd30(wx(m3_p_reg[0]) - wx(m3_p_reg[1]));
        r[1] = rnd30(wx(m3_p_reg[2]) + wx(m3_p_reg[3]));
        r[2] = m3_z_reg;
        rflag = 1'b0;
        out_data_next = 96'h0;
        for (int a = 0; a < 3; a++)
        begin
            if (r[a] > SAT_HI)
            begin
                rflag = 1'b1;
                out_data_next[32*a +: 32] = 32'h7FFFFFFF;
            end
            else if (r[a] < SAT_LO)
            begin
                rflag = 1'b1;
                out_data_next[32*a +: 32] = 32'h80000000;
            end
            else
                out_data_next[32*a +: 32] = r[a][31:0];
        end
        out_flag_next = rflag;
        if (side_reg[NS-2].action != ACT_ROTATE)
        begin
            out_data_next = side_reg[NS-2].alt;
            out_flag_next = side_reg[NS-2].alt_flag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NS; k++)
                v_reg[k] <= 1'b0;
        end
        else
        begin
            if (adv[0])
                v_reg[0] <= in_valid;
            for (int k = 1; k < NS; k++)
                if (adv[k])
                    v_reg[k] <= v_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            side_reg[0] <= side_next;
            tx_reg      <= CW'($signed(in_data.p[0]));
            ty_reg      <= CW'($signed(in_data.p[1]));
            tz_reg      <= CW'($signed(in_data.p[2]));
        end
        for (int k = 1; k < NS - 1; k++)
            if (adv[k])
                side_reg[k] <= side_reg[k-1];
        if (adv[1])
        begin
            m1_x_reg    <= tx_reg;
            m1_p_reg[0] <= ty_reg * $signed(side_reg[0].c[0]);
            m1_p_reg[1] <= tz_reg * $signed(side_reg[0].s[0]);
            m1_p_reg[2] <= ty_reg * $signed(side_reg[0].s[0]);
            m1_p_reg[3] <= tz_reg * $signed(side_reg[0].c[0]);
        end
        if (adv[2])
        begin
            a1_x_reg <= m1_x_reg;
            a1_y_reg <= rnd30(wx(m1_p_reg[0]) - wx(m1_p_reg[1]));
            a1_z_reg <= rnd30(wx(m1_p_reg[2]) + wx(m1_p_reg[3]));
        end
        if (adv[3])
        begin
            m2_y_reg    <= a1_y_reg;
            m2_p_reg[0] <= a1_x_reg * $signed(side_reg[2].c[1]);
            m2_p_reg[1] <= a1_z_reg * $signed(side_reg[2].s[1]);
            m2_p_reg[2] <= a1_z_reg * $signed(side_reg[2].c[1]);
            m2_p_reg[3] <= a1_x_reg * $signed(side_reg[2].s[1]);
        end
        if (adv[4])
        begin
            a2_y_reg <= m2_y_reg;
            a2_x_reg <= rnd30(wx(m2_p_reg[0]) + wx(m2_p_reg[1]));
            a2_z_reg <= rnd30(wx(m2_p_reg[2]) - wx(m2_p_reg[3]));
        end
        if (adv[5])
        begin
            m3_z_reg    <= a2_z_reg;
            m3_p_reg[0] <= a2_x_reg * $signed(side_reg[4].c[2]);
            m3_p_reg[1] <= a2_y_reg * $signed(side_reg[4].s[2]);
            m3_p_reg[2] <= a2_x_reg * $signed(side_reg[4].s[2]);
            m3_p_reg[3] <= a2_y_reg * $signed(side_reg[4].c[2]);
        end
        if (adv[6])
        begin
            out_data_reg <= out_data_next;
            out_flag_reg <= out_flag_next;
        end
    end

endmodule

[design/point_rotate_translate_scale_top.sv]
// Top level: configuration registers, input prep stage, the cell chain and the back end.
// Depends on prts_pkg, prts_cell and prts_post.
//
// Rotates (X, then Y, then Z), translates or displaces one Q-format 3D point per
// transaction. One point is taken every cycle while the output is not stalled; each
// result passes one prep stage, a chain of 32 cells that each run one quotient bit
// of the three displace divisions and, in the first CORDIC_STAGES cells, one CORDIC
// iteration for the three angles, then seven back-end stages (trig map, three
// multiply/round pairs, saturate). Bubbles in the pipe are filled while a result
// waits at the output. Write configuration only when no point is in flight.
module point_rotate_translate_scale_top
    import prts_pkg::*;
#(
    parameter int COORD_FRAC_BITS = 16,
    parameter int CORDIC_STAGES   = 18
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,    // in_x, in_y, in_z
    input  logic [1:0]  s_tuser,    // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,    // out_x, out_y, out_z
    output logic [0:0]  m_tuser     // range_flag
);

    logic [15:0]      angle_reg [3];
    logic [2:0][31:0] offset_reg;

    logic  p0_v_reg;
    cell_t p0_data_reg;
    cell_t p0_next;
    logic  p0_adv;

    logic  cv   [NCELL+1];
    logic  crdy [NCELL+1];
    cell_t cd   [NCELL+1];

    logic signed [16:0] ang [3];
    logic signed [16:0] red [3];
    logic [32:0]        prod_a [3];
    logic [40:0]        prod_b [3];
    logic [31:0]        th [3];
    logic signed [31:0] pt [3];
    logic signed [33:0] dd [3];
    logic [31:0]        ap [3];
    logic [31:0]        ad [3];
    logic [RW-1:0]      num [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < 3; a++)
                angle_reg[a] <= 16'h0;
            offset_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ANGLE_X:  angle_reg[0]  <= cfg_data[15:0];
                REG_ANGLE_Y:  angle_reg[1]  <= cfg_data[15:0];
                REG_ANGLE_Z:  angle_reg[2]  <= cfg_data[15:0];
                REG_OFFSET_X: offset_reg[0] <= cfg_data;
                REG_OFFSET_Y: offset_reg[1] <= cfg_data;
                REG_OFFSET_Z: offset_reg[2] <= cfg_data;
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        p0_next.action = s_tuser;
        for (int a = 0; a < 3; a++)
        begin
            ang[a] = 17'($signed(angle_reg[a]));
            if (ang[a] < -17'sd23040)
                red[a] = ang[a] + 17'sd46080;
            else if (ang[a] < 17'sd0)
                red[a] = ang[a] + 17'sd23040;
            else if (ang[a] >= 17'sd23040)
                red[a] = ang[a] - 17'sd23040;
            else
                red[a] = ang[a];
            prod_a[a] = 33'(red[a][14:0]) * 33'd186413;
            prod_b[a] = 41'(red[a][14:0]) * 41'd34300107;
            th[a]     = prod_a[a][31:0] + 32'(prod_b[a] >> 26);
            p0_next.cord[a].x    = CORDIC_START;
            p0_next.cord[a].y    = '0;
            p0_next.cord[a].z    = $signed({2'b00, th[a][29:0]});
            p0_next.cord[a].quad = th[a][31:30];

            pt[a]        = $signed(s_tdata[32*a +: 32]);
            p0_next.p[a] = s_tdata[32*a +: 32];
            dd[a] = (34'sd1 <<< COORD_FRAC_BITS) - 34'($signed(offset_reg[a]));
            ap[a] = pt[a][31] ? (~s_tdata[32*a +: 32] + 32'd1) : s_tdata[32*a +: 32];
            ad[a] = dd[a][33] ? 32'(-dd[a]) : dd[a][31:0];
            num[a] = (RW'(ap[a]) << COORD_FRAC_BITS) + RW'(ad[a] >> 1);
            p0_next.dv[a].rem  = num[a];
            p0_next.dv[a].den  = ad[a];
            p0_next.dv[a].quo  = '0;
            p0_next.dv[a].ovf  = 64'(num[a]) >= {ad[a], 32'h0};
            p0_next.dv[a].zero = (dd[a] == 34'sd0);
            p0_next.dv[a].neg  = pt[a][31] != dd[a][33];
            p0_next.dv[a].ppos = !pt[a][31] && (pt[a] != 32'sd0);
            p0_next.dv[a].pneg = pt[a][31];
        end
    end

    assign p0_adv   = !p0_v_reg || crdy[0];
    assign s_tready = p0_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p0_v_reg <= 1'b0;
        else if (p0_adv)
            p0_v_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (p0_adv)
            p0_data_reg <= p0_next;
    end

    assign cv[0] = p0_v_reg;
    assign cd[0] = p0_data_reg;

    for (genvar g = 0; g < NCELL; g++)
    begin : g_cell
        prts_cell #(
            .STAGE         (g),
            .CORDIC_STAGES (CORDIC_STAGES)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (cv[g]),
            .in_ready  (crdy[g]),
            .in_data   (cd[g]),
            .out_valid (cv[g+1]),
            .out_ready (crdy[g+1]),
            .out_data  (cd[g+1])
        );
    end

    prts_post u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cv[NCELL]),
        .in_ready  (crdy[NCELL]),
        .in_data   (cd[NCELL]),
        .offset    (offset_reg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_flag  (m_tuser[0])
    );

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !p0_v_reg |-> s_tready)
        else $error("input refused while prep stage empty");

    a_accept_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> p0_v_reg)
        else $error("accepted transaction lost at prep stage");

    a_prep_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (p0_v_reg && !crdy[0]) |=> p0_v_reg)
        else $error("stalled prep stage dropped its transaction");

endmodule

[bench/point_rotate_translate_scale_top_tb.sv]
// Testbench for point_rotate_translate_scale_top: configuration phases with random
// points, checked against a fixed-point predictor of rotate, translate and displace.
// Depends on prts_pkg and the design files.
`timescale 1ns / 1ps

module point_rotate_translate_scale_top_tb;
    import prts_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int FRAC = 16;
    localparam int STAGES = 18;
    localparam int FULL_TURN = 23040;
    localparam int DRAIN_CYCLES = 60;

    typedef struct {
        logic [1:0]   action;
        logic [31:0]  x;
        logic [31:0]  y;
        logic [31:0]  z;
    } point_t;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        flag;
    } result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;
    logic [0:0]  m_tuser;

    point_t  pending_points[$];
    result_t expected_points[$];
    point_t  cur_point;
    int      errors;
    int      send_gap;
    int      stall_len;
    bit      idling_on;

    logic signed [15:0] ang_x, ang_y, ang_z;
    logic signed [31:0] off_x, off_y, off_z;

    point_rotate_translate_scale_top dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #5 clk = ~clk;

    function automatic longint sat32(longint v, inout bit flag);
        if (v > 64'sd2147483647)
        begin
            flag = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            flag = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint round_q30(longint v);
        return (v + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic void angle_trig(logic signed [15:0] ang, output longint c,
                                       output longint s);
        int r;
        longint unsigned th;
        logic [1:0] q;
        longint cx, cy, cz, xs, ys, cc, ss;
        longint one;
        one = 64'sd1 <<< 30;
        r = int'(ang) % FULL_TURN;
        if (r < 0)
            r += FULL_TURN;
        th = (longint'(r) << 32) / FULL_TURN;
        q = th[31:30];
        cz = longint'(th & 64'h3FFF_FFFF);
        cx = 64'sh26DD3B6A;
        cy = 0;
        for (int i = 0; i < STAGES; i++)
        begin
            xs = cx >>> i;
            ys = cy >>> i;
            if (cz >= 0)
            begin
                cx -= ys;
                cy += xs;
                cz -= longint'(atan_val(i));
            end
            else
            begin
                cx += ys;
                cy -= xs;
                cz += longint'(atan_val(i));
            end
        end
        cc = (cx > one) ? one : ((cx < -one) ? -one : cx);
        ss = (cy > one) ? one : ((cy < -one) ? -one : cy);
        case (q)
            2'd0:    begin c = cc;  s = ss;  end
            2'd1:    begin c = -ss; s = cc;  end
            2'd2:    begin c = -cc; s = -ss; end
            default: begin c = ss;  s = -cc; end
        endcase
    endfunction

    function automatic longint displace_coord(longint p, logic signed [31:0] off,
                                              inout bit flag);
        longint d;
        longint unsigned num, den, mag;
        bit neg;
        d = (64'sd1 <<< FRAC) - longint'(off);
        if (d == 0)
        begin
            flag = 1'b1;
            if (p > 0)
                return 64'sd2147483647;
            if (p < 0)
                return -64'sd2147483648;
            return 0;
        end
        neg = (p < 0) != (d < 0);
        num = longint'(p < 0 ? -p : p) << FRAC;
        den = longint'(d < 0 ? -d : d);
        mag = (num + den / 2) / den;
        if (mag > (64'd1 << 40))
            mag = 64'd1 << 40;
        return sat32(neg ? -longint'(mag) : longint'(mag), flag);
    endfunction

    function automatic result_t transform_point(point_t pt);
        result_t res;
        longint x, y, z, c, s, t1, t2;
        bit flag;
        flag = 1'b0;
        x = longint'(signed'(pt.x));
        y = longint'(signed'(pt.y));
        z = longint'(signed'(pt.z));
        case (pt.action)
            ACT_ROTATE:
            begin
                angle_trig(ang_x, c, s);
                t1 = round_q30(y * c - z * s);
                t2 = round_q30(y * s + z * c);
                y = t1;
                z = t2;
                angle_trig(ang_y, c, s);
                t1 = round_q30(x * c + z * s);
                t2 = round_q30(z * c - x * s);
                x = t1;
                z = t2;
                angle_trig(ang_z, c, s);
                t1 = round_q30(x * c - y * s);
                t2 = round_q30(x * s + y * c);
                x = sat32(t1, flag);
                y = sat32(t2, flag);
                z = sat32(z, flag);
            end
            ACT_TRANSLATE:
            begin
                x = sat32(x + longint'(off_x), flag);
                y = sat32(y + longint'(off_y), flag);
                z = sat32(z + longint'(off_z), flag);
            end
            ACT_DISPLACE:
            begin
                x = displace_coord(x, off_x, flag);
                y = displace_coord(y, off_y, flag);
                z = displace_coord(z, off_z, flag);
            end
            default: ;
        endcase
        res.x = x[31:0];
        res.y = y[31:0];
        res.z = z[31:0];
        res.flag = flag;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_points.push_back(transform_point(cur_point));
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    s_tvalid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (pending_points.size() > 0)
                begin
                    cur_point = pending_points.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {cur_point.z, cur_point.y, cur_point.x};
                    s_tuser  <= cur_point.action;
                    if (idling_on && $urandom_range(0, 5) == 0)
                        send_gap <= $urandom_range(1, 8);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            stall_len <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_points.size() == 0)
                    report_mismatch("unexpected out_x", m_tdata[31:0], 32'h0);
                else
                begin
                    want = expected_points.pop_front();
                    if (m_tdata[31:0] !== want.x)
                        report_mismatch("out_x", m_tdata[31:0], want.x);
                    if (m_tdata[63:32] !== want.y)
                        report_mismatch("out_y", m_tdata[63:32], want.y);
                    if (m_tdata[95:64] !== want.z)
                        report_mismatch("out_z", m_tdata[95:64], want.z);
                    if (m_tuser[0] !== want.flag)
                        report_mismatch("range_flag", 32'(m_tuser), 32'(want.flag));
                end
            end
            if (stall_len > 0)
            begin
                m_tready  <= 1'b0;
                stall_len <= stall_len - 1;
            end
            else if (idling_on && $urandom_range(0, 5) == 0)
            begin
                m_tready  <= 1'b0;
                stall_len <= $urandom_range(0, 7);
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic write_reg(logic [2:0] index, logic [31:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        case (index)
            REG_ANGLE_X:  ang_x = value[15:0];
            REG_ANGLE_Y:  ang_y = value[15:0];
            REG_ANGLE_Z:  ang_z = value[15:0];
            REG_OFFSET_X: off_x = value;
            REG_OFFSET_Y: off_y = value;
            default:      off_z = value;
        endcase
    endtask

    task automatic set_config(int ax, int ay, int az, int ox, int oy, int oz);
        write_reg(REG_ANGLE_X, 32'(ax));
        write_reg(REG_ANGLE_Y, 32'(ay));
        write_reg(REG_ANGLE_Z, 32'(az));
        write_reg(REG_OFFSET_X, 32'(ox));
        write_reg(REG_OFFSET_Y, 32'(oy));
        write_reg(REG_OFFSET_Z, 32'(oz));
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_points.size() > 0 || s_tvalid || expected_points.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic add_point(logic [1:0] action, logic [31:0] x, logic [31:0] y,
                             logic [31:0] z);
        point_t pt;
        pt.action = action;
        pt.x = x;
        pt.y = y;
        pt.z = z;
        pending_points.push_back(pt);
    endtask

    function automatic int pick_angle();
        case ($urandom_range(0, 4))
            0:       return FULL_TURN;
            1:       return -FULL_TURN;
            2:       return 5760 * $urandom_range(0, 3);
            default: return int'($urandom_range(0, 2 * FULL_TURN)) - FULL_TURN;
        endcase
    endfunction

    function automatic int pick_offset();
        case ($urandom_range(0, 5))
            0:       return 32'h0001_0000;
            1:       return int'($urandom_range(0, 8191)) - 4096 + 32'h0001_0000;
            2:       return int'($urandom_range(0, 262143)) - 131072;
            3:       return ($urandom_range(0, 1) == 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return int'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 3))
            0:       return 32'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
            1:       return ($urandom_range(0, 1) == 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        point_t pt;
        clk       = 1'b0;
        rst_n     = 1'b0;
        errors    = 0;
        idling_on = 1'b1;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        ang_x = '0; ang_y = '0; ang_z = '0;
        off_x = '0; off_y = '0; off_z = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset values, then extremes and the zero-divisor axes
        add_point(ACT_ROTATE, 32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        add_point(ACT_TRANSLATE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
        add_point(ACT_UNUSED, 32'hDEAD_BEEF, 32'h8000_0000, 32'h7FFF_FFFF);
        wait_drained();
        set_config(5760, 11520, -23040, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
        add_point(ACT_ROTATE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_point(ACT_ROTATE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        add_point(ACT_TRANSLATE, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        add_point(ACT_TRANSLATE, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000);
        add_point(ACT_DISPLACE, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        add_point(ACT_DISPLACE, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        add_point(ACT_DISPLACE, 32'h0, 32'h0, 32'h0);
        add_point(ACT_UNUSED, 32'h1234_5678, 32'h0, 32'hFFFF_FFFF);
        wait_drained();
        set_config(23040, -5760, 17280, 32'h0001_0000, 32'h0000_8000, 32'hFFFF_0000);
        add_point(ACT_ROTATE, 32'h0123_4567, 32'hFEDC_BA98, 32'h0001_0000);
        add_point(ACT_ROTATE, 32'h4000_0000, 32'hC000_0000, 32'h7FFF_FFFF);
        add_point(ACT_DISPLACE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        add_point(ACT_DISPLACE, 32'h8000_0000, 32'h0003_0001, 32'h0000_0003);
        add_point(ACT_TRANSLATE, 32'h0, 32'h7FFF_0000, 32'h8000_0000);
        wait_drained();
        set_config(-11520, 1, -1, 32'h0, 32'h0, 32'h0);
        add_point(ACT_ROTATE, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
        add_point(ACT_DISPLACE, 32'h0001_8000, 32'hFFFF_8000, 32'h0000_0001);
        wait_drained();

        // Random phases; the last ones run without idling
        for (int phase = 0; phase < 20; phase++)
        begin
            if (phase >= 17)
                idling_on = 1'b0;
            set_config(pick_angle(), pick_angle(), pick_angle(),
                       pick_offset(), pick_offset(), pick_offset());
            for (int n = 0; n < 100; n++)
            begin
                pt.action = ($urandom_range(0, 15) == 0) ? ACT_UNUSED
                                                         : 2'($urandom_range(0, 2));
                pt.x = pick_coord();
                pt.y = pick_coord();
                pt.z = pick_coord();
                pending_points.push_back(pt);
            end
            wait_drained();
        end

        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
